FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the capture ring.
// Simulation builds get concurrent checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/rmcb_pkg.sv
// Package for the roll-mode capture ring: commands, register indexes,
// reset values and field widths. No dependencies.
package rmcb_pkg;

  localparam int MAX_CHANNEL_BYTES_DEF = 8192;

  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int DIST_W   = 14;
  localparam int SIZE_W   = 14;
  localparam int WPOS_W   = 13;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 88;
  localparam int M_TUSER_W = 1;

  localparam int SIZE_RST = 512;
  localparam logic [BYTE_W-1:0] MARKER_RST = '0;
  localparam logic PEAK_RST = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_DETECT  = 2'd0,
    REG_CHANNEL_SIZE = 2'd1,
    REG_EMPTY_MARKER = 2'd2
  } reg_idx_t;

  // Result stage contents (read data itself comes from the RAM output reg).
  typedef struct packed {
    logic                from_mem;
    logic                ch;
    logic [BYTE_W-1:0]   rd_const;
    logic                beyond;
    logic [WPOS_W-1:0]   wpos;
    logic [COUNT_W-1:0]  points;
    logic [COUNT_W-1:0]  bytes;
  } result_t;

endpackage

FILE: rtl/rmcb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rmcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/roll_mode_capture_buffer_unit.sv
// Top level of the two-channel roll-mode capture ring with peak detect.
// Depends on rmcb_pkg, rmcb_ram and assert_macros.svh.
//
// channel  dir  handshake          payload
// -------  ---  -----------------  ----------------------------------------------
// s_*      in   s_tvalid/s_tready  tuser: command, channel; tdata: samples, distance
// m_*      out  m_tvalid/m_tready  tuser: beyond_ring; tdata: read byte, status
// cfg_*    in   cfg_valid/cfg_ready register index + data, always ready
//
// One item per cycle while m_tready does not stall, except an add with peak
// detect on: it holds the input register for a write per byte, as each RAM has one write port.
// An item is registered in the input reg, then in the result stage and RAM read reg.
// After reset a clearing pass zeroes every address of both rings;
// s_tready stays low until it ends, config writes are taken meanwhile.
// m_tready low stalls the result stage, then the input register, then s_tready.
`include "assert_macros.svh"

module roll_mode_capture_buffer_unit #(
  parameter int MAX_CHANNEL_BYTES = rmcb_pkg::MAX_CHANNEL_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] sample_a, [31:16] sample_b, [45:32] distance, [47:46] zero
  input  logic [rmcb_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] command, [2] channel
  input  logic [rmcb_pkg::S_TUSER_W-1:0] s_tuser,
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] read_data, [20:8] write_position, [52:21] point_count,
  // [84:53] byte_count, [87:85] zero
  output logic [rmcb_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] beyond_ring
  output logic [rmcb_pkg::M_TUSER_W-1:0] m_tuser,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmcb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_CHANNEL_BYTES);      // ring address
  localparam int SW = $clog2(MAX_CHANNEL_BYTES + 1);  // ring size
  localparam int CW = ((SW > rmcb_pkg::DIST_W) ? SW : rmcb_pkg::DIST_W) + 1;
  localparam int SIZE_RST_CLAMP =
    (rmcb_pkg::SIZE_RST < MAX_CHANNEL_BYTES) ? rmcb_pkg::SIZE_RST : MAX_CHANNEL_BYTES;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CHANNEL_BYTES);
  localparam logic [CW-1:0] MIN_C = CW'(2);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CHANNEL_BYTES - 1);
  localparam int B = rmcb_pkg::BYTE_W;
  localparam int C = rmcb_pkg::COUNT_W;

  // ---------------- configuration registers ----------------
  logic          peak;
  logic [SW-1:0] sz;        // channel size already clamped to 2..MAX
  logic [B-1:0]  marker;
  logic [CW-1:0] cfg_size_raw;
  logic [SW-1:0] cfg_size_clamped;
  logic          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    cfg_size_raw = CW'(cfg_data[rmcb_pkg::SIZE_W-1:0]);
    if (cfg_size_raw < MIN_C) begin
      cfg_size_clamped = SW'(MIN_C);
    end else if (cfg_size_raw > MAX_C) begin
      cfg_size_clamped = SW'(MAX_C);
    end else begin
      cfg_size_clamped = SW'(cfg_size_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= rmcb_pkg::PEAK_RST;
      sz     <= SW'(SIZE_RST_CLAMP);
      marker <= rmcb_pkg::MARKER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rmcb_pkg::REG_PEAK_DETECT:  peak   <= cfg_data[0];
        rmcb_pkg::REG_CHANNEL_SIZE: sz     <= cfg_size_clamped;
        rmcb_pkg::REG_EMPTY_MARKER: marker <= cfg_data[B-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass ----------------
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---------------- input register (stage 1) ----------------
  logic                          s1_valid;
  rmcb_pkg::cmd_t                s1_cmd;
  logic [rmcb_pkg::SAMPLE_W-1:0] s1_sa;
  logic [rmcb_pkg::SAMPLE_W-1:0] s1_sb;
  logic                          s1_ch;
  logic [rmcb_pkg::DIST_W-1:0]   s1_dist;
  logic                          phase;      // low byte of a peak add done
  logic                          first_half;
  logic                          s2_load;
  logic                          s1_go;
  logic                          accept;

  assign first_half = s1_valid && (s1_cmd == rmcb_pkg::CMD_ADD) && peak && !phase;
  assign s1_go      = s1_valid && !first_half && s2_load;
  assign s_tready   = !clr_active && (!s1_valid || s1_go);
  assign accept     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (first_half) begin
        phase <= 1'b1;
      end else if (s1_go) begin
        phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= rmcb_pkg::cmd_t'(s_tuser[1:0]);
      s1_ch   <= s_tuser[2];
      s1_sa   <= s_tdata[15:0];
      s1_sb   <= s_tdata[31:16];
      s1_dist <= s_tdata[45:32];
    end
  end

  // ---------------- ring state and per-item logic ----------------
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_inc;       // write position after one byte
  logic [AW-1:0] wp_after;     // write position reported with this item
  logic [AW-1:0] wp_next;
  logic [C-1:0]  points;
  logic [C-1:0]  points_after;
  logic [C-1:0]  bytes_after;
  logic [SW-1:0] wp_plus1;
  logic          is_add;
  logic          byte_wr;
  logic          is_read;
  logic          beyond;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] sz_c;
  logic [CW-1:0] dist_c;
  logic [CW-1:0] idx_c;
  logic [AW-1:0] ridx;

  assign is_add   = s1_valid && (s1_cmd == rmcb_pkg::CMD_ADD);
  assign byte_wr  = is_add && (first_half || s1_go);
  assign wp_plus1 = SW'(wp) + SW'(1);
  assign wp_inc   = (wp_plus1 >= sz) ? '0 : AW'(wp_plus1);

  // Item effect on position and count, taken when the item leaves stage 1.
  always_comb begin
    wp_after     = wp;
    points_after = points;
    is_read      = 1'b0;
    unique case (s1_cmd)
      rmcb_pkg::CMD_ADD: begin
        wp_after     = wp_inc;
        points_after = (&points) ? points : points + C'(1);
      end
      rmcb_pkg::CMD_READ: begin
        is_read = 1'b1;
      end
      rmcb_pkg::CMD_START: begin
        wp_after     = '0;
        points_after = '0;
      end
      default: ;
    endcase
  end

  // Peak detect doubles the byte count, saturating.
  assign bytes_after = !peak ? points_after :
                       points_after[C-1] ? '1 : {points_after[C-2:0], 1'b0};

  // Read address: step back from the write position, wrap below zero.
  assign pos_c  = CW'(wp);
  assign sz_c   = CW'(sz);
  assign dist_c = CW'(s1_dist);
  assign beyond = dist_c > sz_c;
  always_comb begin
    if (dist_c <= pos_c) begin
      idx_c = pos_c - dist_c;
    end else begin
      idx_c = sz_c + pos_c - dist_c;
    end
    ridx = (idx_c >= sz_c) ? '0 : AW'(idx_c);
  end

  // Position update; a shrinking size pulls it back to zero.
  always_comb begin
    wp_next = wp;
    if (cfg_wr && (cfg_index == rmcb_pkg::REG_CHANNEL_SIZE)) begin
      if (SW'(wp) >= cfg_size_clamped) begin
        wp_next = '0;
      end
    end else if (first_half) begin
      wp_next = wp_inc;
    end else if (s1_go) begin
      wp_next = wp_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      points <= '0;
    end else begin
      wp <= wp_next;
      if (s1_go) begin
        points <= points_after;
      end
    end
  end

  // ---------------- channel RAMs ----------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [B-1:0]  wdata_a;
  logic [B-1:0]  wdata_b;
  logic          ram_re;
  logic [B-1:0]  rdata_a;
  logic [B-1:0]  rdata_b;

  // With peak detect, peak byte (low) first, main byte (high) second; else only the main byte.
  always_comb begin
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      wdata_a   = '0;
      wdata_b   = '0;
    end else begin
      ram_we    = byte_wr;
      ram_waddr = wp;
      wdata_a   = first_half ? s1_sa[B-1:0] : s1_sa[2*B-1:B];
      wdata_b   = first_half ? s1_sb[B-1:0] : s1_sb[2*B-1:B];
    end
  end

  assign ram_re = s1_go && is_read && !beyond;

  rmcb_ram #(
    .WIDTH (B),
    .DEPTH (MAX_CHANNEL_BYTES)
  ) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata_a),
    .re    (ram_re),
    .raddr (ridx),
    .rdata (rdata_a)
  );

  rmcb_ram #(
    .WIDTH (B),
    .DEPTH (MAX_CHANNEL_BYTES)
  ) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata_b),
    .re    (ram_re),
    .raddr (ridx),
    .rdata (rdata_b)
  );

  // ---------------- result stage (stage 2) ----------------
  logic              s2_valid;
  rmcb_pkg::result_t s2;
  logic [B-1:0]      read_data;

  assign s2_load = !s2_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2.from_mem <= is_read && !beyond;
      s2.ch       <= s1_ch;
      s2.rd_const <= (is_read && beyond) ? marker : '0;
      s2.beyond   <= is_read && beyond;
      s2.wpos     <= rmcb_pkg::WPOS_W'(wp_after);
      s2.points   <= points_after;
      s2.bytes    <= bytes_after;
    end
  end

  // RAM read register holds while stalled: no read is issued until s2 moves.
  assign read_data = s2.from_mem ? (s2.ch ? rdata_b : rdata_a) : s2.rd_const;

  assign m_tvalid = s2_valid;
  assign m_tdata  = {3'b000, s2.bytes, s2.points, s2.wpos, read_data};
  assign m_tuser  = s2.beyond;

  // ---------------- checks ----------------
  `ASSERT_ALWAYS(a_wp_in_ring, clk, rst, SW'(wp) < sz, "write position outside ring")
  `ASSERT_IMPLIES(a_phase_peak_add, clk, rst, phase,
                  s1_valid && (s1_cmd == rmcb_pkg::CMD_ADD) && peak,
                  "second byte phase without a peak add")
  `ASSERT_IMPLIES(a_no_item_in_clear, clk, rst, clr_active, !s1_valid && !s2_valid,
                  "item in flight during clearing pass")
  `ASSERT_IMPLIES(a_beyond_not_mem, clk, rst, s2_valid && s2.beyond, !s2.from_mem,
                  "beyond-ring read also marked as RAM read")
  `ASSERT_NEXT(a_points_sat, clk, rst, (&points) && s1_go && is_add, &points,
               "point count wrapped past saturation")

endmodule
